[hw/rtl/stop_target_path_labeler_macros.svh]
// Assertion helpers for the path labeler.
// Both expect clk and rst in scope.
`ifndef STOP_TARGET_PATH_LABELER_MACROS_SVH
`define STOP_TARGET_PATH_LABELER_MACROS_SVH

// Same-cycle implication.
`define STPL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stpl: same-cycle check failed");

// Next-cycle implication.
`define STPL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stpl: next-cycle check failed");

`endif

[hw/rtl/stpl_pkg.sv]
`default_nettype none
package stpl_pkg;

  // Datapath sizing
  localparam int PRICE_BITS = 32;
  localparam int COUNT_BITS = 12;
  localparam int PROD_W     = PRICE_BITS + 16;
  localparam int SD_W       = PRICE_BITS + 8;
  localparam int TD_W       = PRICE_BITS + 9;
  localparam int LVL_W      = PRICE_BITS + 3;
  localparam int WIDE_W     = PRICE_BITS + 11;

  // Port widths
  localparam int IN_PRICE_W = 32;
  localparam int OUT_CNT_W  = 12;
  localparam int FRAC_W     = 16;
  localparam int MAXB_W     = 12;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int BC_W       = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

  // Register indexes
  localparam logic [2:0] REG_STOP_FRAC   = 3'd0;
  localparam logic [2:0] REG_STOP_MULT   = 3'd1;
  localparam logic [2:0] REG_TARGET_MULT = 3'd2;
  localparam logic [2:0] REG_COST_FRAC   = 3'd3;
  localparam logic [2:0] REG_MAX_BARS    = 3'd4;

  // Labels
  localparam logic [1:0] LABEL_NONE  = 2'd0;
  localparam logic [1:0] LABEL_LONG  = 2'd1;
  localparam logic [1:0] LABEL_SHORT = 2'd2;

  // Microcode field codes
  localparam logic       ASEL_ENTRY  = 1'b0;
  localparam logic       ASEL_ONE_R  = 1'b1;
  localparam logic [1:0] BSEL_SF     = 2'd0;
  localparam logic [1:0] BSEL_CB     = 2'd1;
  localparam logic [1:0] BSEL_SM     = 2'd2;
  localparam logic [1:0] BSEL_TM     = 2'd3;
  localparam logic [2:0] DST_NONE    = 3'd0;
  localparam logic [2:0] DST_ONE_R   = 3'd1;
  localparam logic [2:0] DST_COST    = 3'd2;
  localparam logic [2:0] DST_SD      = 3'd3;
  localparam logic [2:0] DST_TD      = 3'd4;
  localparam logic [1:0] LVL_NONE    = 2'd0;
  localparam logic [1:0] LVL_STOPS   = 2'd1;
  localparam logic [1:0] LVL_TARGETS = 2'd2;

  // Program layout
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] START_PC = 3'd0;
  localparam logic [PC_W-1:0] BAR_PC   = 3'd7;

  typedef logic [PRICE_BITS-1:0] price_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [SD_W-1:0]       sd_t;
  typedef logic [TD_W-1:0]       td_t;
  typedef logic [BC_W-1:0]       bcmp_t;
  typedef logic signed [LVL_W-1:0]  level_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic [FRAC_W-1:0] stop_fraction;
    logic [FRAC_W-1:0] stop_multiple;
    logic [FRAC_W-1:0] target_multiple;
    logic [FRAC_W-1:0] cost_buffer_fraction;
    logic [MAXB_W-1:0] max_bars;
  } cfg_t;

  typedef struct packed {
    logic       clr;     // start of a new path
    logic       jz;      // end program if entry or stop fraction is zero
    logic       fin;     // last step
    logic       mul_en;
    logic       a_sel;
    logic [1:0] b_sel;
    logic [2:0] dst;
    logic [1:0] lvl;
    logic       bar;     // evaluate a bar beat
  } uop_t;

  typedef struct packed {
    logic go;
    uop_t uop;
  } ctl_t;

  typedef struct packed {
    logic   path_valid;
    count_t bars_seen;
    count_t long_count;
    count_t short_count;
  } stat_t;

  // Microcode ROM
  function automatic uop_t ucode_rom(logic [PC_W-1:0] pc);
    uop_t u;
    u = '0;
    unique case (pc)
      3'd0: begin
        u.clr = 1'b1; u.jz = 1'b1;
        u.mul_en = 1'b1; u.a_sel = ASEL_ENTRY; u.b_sel = BSEL_SF;
      end
      3'd1: begin
        u.dst = DST_ONE_R;
        u.mul_en = 1'b1; u.a_sel = ASEL_ENTRY; u.b_sel = BSEL_CB;
      end
      3'd2: begin
        u.dst = DST_COST;
        u.mul_en = 1'b1; u.a_sel = ASEL_ONE_R; u.b_sel = BSEL_SM;
      end
      3'd3: begin
        u.dst = DST_SD;
        u.mul_en = 1'b1; u.a_sel = ASEL_ONE_R; u.b_sel = BSEL_TM;
      end
      3'd4: begin
        u.dst = DST_TD;
      end
      3'd5: begin
        u.lvl = LVL_STOPS;
      end
      3'd6: begin
        u.lvl = LVL_TARGETS; u.fin = 1'b1;
      end
      3'd7: begin
        u.bar = 1'b1; u.fin = 1'b1;
      end
    endcase
    return u;
  endfunction

  // Saturate a wide signed value to level width
  function automatic level_t sat_level(wide_t v);
    wide_t hi;
    wide_t lo;
    hi = wide_t'({1'b0, {(LVL_W-1){1'b1}}});
    lo = -hi - wide_t'(1);
    if (v > hi) begin
      return level_t'(hi);
    end else if (v < lo) begin
      return level_t'(lo);
    end
    return level_t'(v);
  endfunction

  // Fit a count to the output port width
  function automatic logic [OUT_CNT_W-1:0] out_count(count_t c);
    bcmp_t t;
    t = bcmp_t'(c);
    return t[OUT_CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/stop_target_path_labeler.sv]
// Start beat: 7 sequencer steps on one shared multiplier (1 step for a zero
//   entry or zero stop fraction); a new beat is taken once the steps have ended.
// Bar beat: 1 compare step, which for a last bar waits while a stalled result is
//   still held; the result of a last bar is registered from that step.
// Synchronous active-high reset: config registers return to defaults,
//   path state and levels clear, no result is pending.
`default_nettype none
`include "stop_target_path_labeler_macros.svh"
module stop_target_path_labeler (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [stpl_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [stpl_pkg::DATA_W-1:0]        pwdata,
  output logic [stpl_pkg::DATA_W-1:0]             prdata,
  output logic                                    pready,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               action,
  input  wire logic [stpl_pkg::IN_PRICE_W-1:0]    entry_price,
  input  wire logic [stpl_pkg::IN_PRICE_W-1:0]    bar_high,
  input  wire logic [stpl_pkg::IN_PRICE_W-1:0]    bar_low,
  input  wire logic                               last_bar,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              label,
  output logic                                    long_target_first,
  output logic [stpl_pkg::OUT_CNT_W-1:0]          long_bar_count,
  output logic                                    short_target_first,
  output logic [stpl_pkg::OUT_CNT_W-1:0]          short_bar_count
);

  stpl_pkg::cfg_t  cfg;
  stpl_pkg::ctl_t  ctl;
  stpl_pkg::stat_t stat;
  logic            busy;
  logic            accept;
  logic            zero_cond;
  logic            blocked;
  logic            cfg_wr;
  logic [2:0]      reg_idx;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = paddr[4:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_fraction        <= 16'd655;
      cfg.stop_multiple        <= 16'd256;
      cfg.target_multiple      <= 16'd512;
      cfg.cost_buffer_fraction <= 16'd0;
      cfg.max_bars             <= 12'd20;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        stpl_pkg::REG_STOP_FRAC:   cfg.stop_fraction        <= pwdata[15:0];
        stpl_pkg::REG_STOP_MULT:   cfg.stop_multiple        <= pwdata[15:0];
        stpl_pkg::REG_TARGET_MULT: cfg.target_multiple      <= pwdata[15:0];
        stpl_pkg::REG_COST_FRAC:   cfg.cost_buffer_fraction <= pwdata[15:0];
        stpl_pkg::REG_MAX_BARS:    cfg.max_bars             <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      stpl_pkg::REG_STOP_FRAC:   prdata = stpl_pkg::DATA_W'(cfg.stop_fraction);
      stpl_pkg::REG_STOP_MULT:   prdata = stpl_pkg::DATA_W'(cfg.stop_multiple);
      stpl_pkg::REG_TARGET_MULT: prdata = stpl_pkg::DATA_W'(cfg.target_multiple);
      stpl_pkg::REG_COST_FRAC:   prdata = stpl_pkg::DATA_W'(cfg.cost_buffer_fraction);
      stpl_pkg::REG_MAX_BARS:    prdata = stpl_pkg::DATA_W'(cfg.max_bars);
      default:                   prdata = '0;
    endcase
  end

  stpl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .is_bar    (action),
    .zero_cond (zero_cond),
    .blocked   (blocked),
    .ctl       (ctl),
    .busy      (busy)
  );

  stpl_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .ctl                (ctl),
    .cfg                (cfg),
    .accept             (accept),
    .entry_price        (entry_price),
    .bar_high           (bar_high),
    .bar_low            (bar_low),
    .last_bar           (last_bar),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .label              (label),
    .long_target_first  (long_target_first),
    .long_bar_count     (long_bar_count),
    .short_target_first (short_target_first),
    .short_bar_count    (short_bar_count),
    .zero_cond          (zero_cond),
    .blocked            (blocked),
    .stat               (stat)
  );

  // A start beat never yields a result
  `STPL_ASSERT_NXT(a_start_no_result, accept && !action, !$rose(out_valid))
  // No bar is counted outside a valid path
  `STPL_ASSERT_IMP(a_idle_path_clear, !stat.path_valid, stat.bars_seen == '0)
  // Resolution bar numbers never exceed the bars examined
  `STPL_ASSERT_IMP(a_count_bound, 1'b1,
    (stat.long_count <= stat.bars_seen) && (stat.short_count <= stat.bars_seen))
  // A stalled result stays valid and unchanged
  `STPL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable({label,
    long_target_first, long_bar_count, short_target_first, short_bar_count}))

endmodule
`default_nettype wire

[hw/rtl/stpl_seq.sv]
`default_nettype none
module stpl_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          is_bar,
  input  wire logic          zero_cond,
  input  wire logic          blocked,
  output stpl_pkg::ctl_t     ctl,
  output logic               busy
);

  logic [stpl_pkg::PC_W-1:0] pc;
  stpl_pkg::uop_t            uop;
  logic                      go;
  logic                      done;

  // Decode current step; a last-bar step waits while a stalled result is held
  always_comb begin
    uop  = stpl_pkg::ucode_rom(pc);
    go   = busy && !(uop.bar && blocked);
    done = uop.fin || (uop.jz && zero_cond);
    ctl.go  = go;
    ctl.uop = uop;
  end

  // Step counter with entry dispatch and conditional end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= stpl_pkg::START_PC;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= is_bar ? stpl_pkg::BAR_PC : stpl_pkg::START_PC;
    end else if (go) begin
      if (done) begin
        busy <= 1'b0;
      end else begin
        pc <= pc + stpl_pkg::PC_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/stpl_dp.sv]
`default_nettype none
module stpl_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire stpl_pkg::ctl_t                     ctl,
  input  wire stpl_pkg::cfg_t                     cfg,
  input  wire logic                               accept,
  input  wire logic [stpl_pkg::IN_PRICE_W-1:0]    entry_price,
  input  wire logic [stpl_pkg::IN_PRICE_W-1:0]    bar_high,
  input  wire logic [stpl_pkg::IN_PRICE_W-1:0]    bar_low,
  input  wire logic                               last_bar,
  input  wire logic                               out_stall,
  output logic                                    out_valid,
  output logic [1:0]                              label,
  output logic                                    long_target_first,
  output logic [stpl_pkg::OUT_CNT_W-1:0]          long_bar_count,
  output logic                                    short_target_first,
  output logic [stpl_pkg::OUT_CNT_W-1:0]          short_bar_count,
  output logic                                    zero_cond,
  output logic                                    blocked,
  output stpl_pkg::stat_t                         stat
);

  // Latched item
  stpl_pkg::price_t entry_q, high_q, low_q;
  logic             last_q;

  // Arithmetic registers
  stpl_pkg::prod_t  prod;
  stpl_pkg::price_t one_r;
  stpl_pkg::price_t cost;
  stpl_pkg::sd_t    sd;
  stpl_pkg::td_t    td;

  stpl_pkg::level_t long_stop_level, long_target_level;
  stpl_pkg::level_t short_stop_level, short_target_level;

  // Path state
  logic             path_valid;
  stpl_pkg::count_t bars_seen;
  logic             long_resolved, long_hit_target;
  logic             short_resolved, short_hit_target;
  stpl_pkg::count_t long_count, short_count;

  // Multiplier operands
  stpl_pkg::price_t  mul_a;
  logic [15:0]       mul_b;

  // Level sums
  stpl_pkg::wide_t   w_entry, w_sd, w_td;

  // Bar evaluation
  logic              examine;
  stpl_pkg::count_t  n;
  stpl_pkg::level_t  hi_l, lo_l;
  logic              lr_next, lh_next, sr_next, sh_next;
  stpl_pkg::count_t  lc_next, sc_next, bs_next;
  logic              emit, bar_go;

  assign zero_cond = (entry_q == '0) || (cfg.stop_fraction == '0);
  assign blocked   = out_valid && out_stall && last_q;
  assign bar_go    = ctl.go && ctl.uop.bar;
  assign emit      = bar_go && last_q;

  assign stat.path_valid  = path_valid;
  assign stat.bars_seen   = bars_seen;
  assign stat.long_count  = long_count;
  assign stat.short_count = short_count;

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_q <= stpl_pkg::price_t'(entry_price);
      high_q  <= stpl_pkg::price_t'(bar_high);
      low_q   <= stpl_pkg::price_t'(bar_low);
      last_q  <= last_bar;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = (ctl.uop.a_sel == stpl_pkg::ASEL_ONE_R) ? one_r : entry_q;
    unique case (ctl.uop.b_sel)
      stpl_pkg::BSEL_SF: mul_b = cfg.stop_fraction;
      stpl_pkg::BSEL_CB: mul_b = cfg.cost_buffer_fraction;
      stpl_pkg::BSEL_SM: mul_b = cfg.stop_multiple;
      stpl_pkg::BSEL_TM: mul_b = cfg.target_multiple;
    endcase
  end

  // Registered product and distance registers
  always_ff @(posedge clk) begin
    if (ctl.go && ctl.uop.mul_en) begin
      prod <= stpl_pkg::prod_t'(mul_a) * stpl_pkg::prod_t'(mul_b);
    end
    if (ctl.go) begin
      unique case (ctl.uop.dst)
        stpl_pkg::DST_ONE_R: one_r <= prod[stpl_pkg::PROD_W-1:16];
        stpl_pkg::DST_COST:  cost  <= prod[stpl_pkg::PROD_W-1:16];
        stpl_pkg::DST_SD:    sd    <= prod[stpl_pkg::PROD_W-1:8];
        stpl_pkg::DST_TD:    td    <= stpl_pkg::td_t'(cost)
                                      + stpl_pkg::td_t'(prod[stpl_pkg::PROD_W-1:8]);
        default: ;
      endcase
    end
  end

  // Level arithmetic in a wide signed domain
  always_comb begin
    w_entry = stpl_pkg::wide_t'(entry_q);
    w_sd    = stpl_pkg::wide_t'(sd);
    w_td    = stpl_pkg::wide_t'(td);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_stop_level    <= '0;
      long_target_level  <= '0;
      short_stop_level   <= '0;
      short_target_level <= '0;
    end else if (ctl.go && ctl.uop.lvl == stpl_pkg::LVL_STOPS) begin
      long_stop_level    <= stpl_pkg::sat_level(w_entry - w_sd);
      short_stop_level   <= stpl_pkg::sat_level(w_entry + w_sd);
    end else if (ctl.go && ctl.uop.lvl == stpl_pkg::LVL_TARGETS) begin
      long_target_level  <= stpl_pkg::sat_level(w_entry + w_td);
      short_target_level <= stpl_pkg::sat_level(w_entry - w_td);
    end
  end

  // Bar compare against the four levels; stop wins a shared bar
  always_comb begin
    hi_l    = stpl_pkg::level_t'(high_q);
    lo_l    = stpl_pkg::level_t'(low_q);
    examine = path_valid
              && (stpl_pkg::bcmp_t'(bars_seen) < stpl_pkg::bcmp_t'(cfg.max_bars))
              && (bars_seen != stpl_pkg::COUNT_MAX);
    n       = bars_seen + stpl_pkg::count_t'(1);
    bs_next = bars_seen;
    lr_next = long_resolved;
    lh_next = long_hit_target;
    lc_next = long_count;
    sr_next = short_resolved;
    sh_next = short_hit_target;
    sc_next = short_count;
    if (examine) begin
      bs_next = n;
      if (!long_resolved) begin
        if (lo_l <= long_stop_level) begin
          lr_next = 1'b1; lc_next = n;
        end else if (hi_l >= long_target_level) begin
          lr_next = 1'b1; lh_next = 1'b1; lc_next = n;
        end
      end
      if (!short_resolved) begin
        if (hi_l >= short_stop_level) begin
          sr_next = 1'b1; sc_next = n;
        end else if (lo_l <= short_target_level) begin
          sr_next = 1'b1; sh_next = 1'b1; sc_next = n;
        end
      end
    end
  end

  // Path state: cleared on start and after the last bar
  always_ff @(posedge clk) begin
    if (rst || (ctl.go && ctl.uop.clr) || emit) begin
      path_valid       <= 1'b0;
      bars_seen        <= '0;
      long_resolved    <= 1'b0;
      long_hit_target  <= 1'b0;
      long_count       <= '0;
      short_resolved   <= 1'b0;
      short_hit_target <= 1'b0;
      short_count      <= '0;
    end else if (bar_go) begin
      bars_seen        <= bs_next;
      long_resolved    <= lr_next;
      long_hit_target  <= lh_next;
      long_count       <= lc_next;
      short_resolved   <= sr_next;
      short_hit_target <= sh_next;
      short_count      <= sc_next;
    end else if (ctl.go && ctl.uop.lvl == stpl_pkg::LVL_TARGETS) begin
      path_valid <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (emit) begin
      label              <= lh_next ? stpl_pkg::LABEL_LONG :
                            (sh_next ? stpl_pkg::LABEL_SHORT : stpl_pkg::LABEL_NONE);
      long_target_first  <= lh_next;
      long_bar_count     <= stpl_pkg::out_count(lc_next);
      short_target_first <= sh_next;
      short_bar_count    <= stpl_pkg::out_count(sc_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[tb/tb_stop_target_path_labeler.sv]
`timescale 1ns / 1ps

module tb_stop_target_path_labeler;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BAR = 1'b1;
  localparam int IDLE_MAX = 17;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 600;
  localparam longint LEVEL_TOP = (longint'(1) << (stpl_pkg::LVL_W - 1)) - 1;
  localparam longint LEVEL_BOT = -LEVEL_TOP - 1;
  localparam longint PRICE_TOP = (longint'(1) << stpl_pkg::IN_PRICE_W) - 1;

  typedef struct packed {
    logic              action;
    stpl_pkg::price_t  entry;
    stpl_pkg::price_t  high;
    stpl_pkg::price_t  low;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic [1:0]                     label;
    logic                           long_first;
    logic [stpl_pkg::OUT_CNT_W-1:0] long_bars;
    logic                           short_first;
    logic [stpl_pkg::OUT_CNT_W-1:0] short_bars;
  } verdict_t;

  // DUT ports
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [stpl_pkg::ADDR_W-1:0]     paddr = '0;
  logic [stpl_pkg::DATA_W-1:0]     pwdata = '0;
  logic [stpl_pkg::DATA_W-1:0]     prdata;
  logic                            pready;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            action = 1'b0;
  logic [stpl_pkg::IN_PRICE_W-1:0] entry_price = '0;
  logic [stpl_pkg::IN_PRICE_W-1:0] bar_high = '0;
  logic [stpl_pkg::IN_PRICE_W-1:0] bar_low = '0;
  logic                            last_bar = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      label;
  logic                            long_target_first;
  logic [stpl_pkg::OUT_CNT_W-1:0]  long_bar_count;
  logic                            short_target_first;
  logic [stpl_pkg::OUT_CNT_W-1:0]  short_bar_count;

  // Register mirror and path tracker state
  stpl_pkg::cfg_t   cfg_m;
  stpl_pkg::level_t long_stop_lv = '0;
  stpl_pkg::level_t long_tgt_lv = '0;
  stpl_pkg::level_t short_stop_lv = '0;
  stpl_pkg::level_t short_tgt_lv = '0;
  logic             path_ok = 1'b0;
  stpl_pkg::count_t bars_seen = '0;
  stpl_pkg::count_t long_bars = '0;
  stpl_pkg::count_t short_bars = '0;
  logic             long_done = 1'b0;
  logic             long_tgt_hit = 1'b0;
  logic             short_done = 1'b0;
  logic             short_tgt_hit = 1'b0;

  verdict_t verdict_q[$];
  beat_t    pending_beats[$];
  int       beats_queued = 0;
  int       beats_taken = 0;
  int       err_count = 0;
  logic     pressure_go = 1'b0;
  logic     hold_off = 1'b0;

  // Driver / monitor locals
  beat_t    cur_beat;
  int       tx_gap = 0;
  logic     tx_burst = 1'b0;
  logic     tx_next;
  int       rx_wait = 0;
  logic     rx_burst = 1'b0;
  verdict_t want;

  stop_target_path_labeler uut (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .action             (action),
    .entry_price        (entry_price),
    .bar_high           (bar_high),
    .bar_low            (bar_low),
    .last_bar           (last_bar),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .label              (label),
    .long_target_first  (long_target_first),
    .long_bar_count     (long_bar_count),
    .short_target_first (short_target_first),
    .short_bar_count    (short_bar_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // Path tracker
  // ---------------------------------------------------------------
  function automatic stpl_pkg::level_t clip_level(longint v);
    if (v > LEVEL_TOP) return stpl_pkg::level_t'(LEVEL_TOP);
    if (v < LEVEL_BOT) return stpl_pkg::level_t'(LEVEL_BOT);
    return stpl_pkg::level_t'(v);
  endfunction

  function automatic void clear_path();
    path_ok = 1'b0;
    bars_seen = '0;
    long_done = 1'b0;
    long_tgt_hit = 1'b0;
    long_bars = '0;
    short_done = 1'b0;
    short_tgt_hit = 1'b0;
    short_bars = '0;
  endfunction

  function automatic void track_beat(beat_t b);
    logic [47:0]      prod_r;
    logic [47:0]      prod_s;
    logic [47:0]      prod_g;
    logic [47:0]      prod_c;
    logic [31:0]      one_r;
    logic [39:0]      sd;
    logic [40:0]      td;
    longint           e;
    longint           s;
    longint           t;
    longint           hi_p;
    longint           lo_p;
    stpl_pkg::count_t n;
    verdict_t         v;
    if (b.action == ACT_START) begin
      clear_path();
      if (b.entry == '0 || cfg_m.stop_fraction == '0) return;
      // one R, then stop and target distances, all truncated
      prod_r = b.entry * cfg_m.stop_fraction;
      one_r = prod_r[47:16];
      prod_s = one_r * cfg_m.stop_multiple;
      prod_g = one_r * cfg_m.target_multiple;
      prod_c = b.entry * cfg_m.cost_buffer_fraction;
      sd = prod_s[47:8];
      td = prod_g[47:8] + prod_c[47:16];
      e = b.entry;
      s = sd;
      t = td;
      long_stop_lv = clip_level(e - s);
      long_tgt_lv = clip_level(e + t);
      short_stop_lv = clip_level(e + s);
      short_tgt_lv = clip_level(e - t);
      path_ok = 1'b1;
      return;
    end
    hi_p = b.high;
    lo_p = b.low;
    // examine bar only inside the window; stop beats target on one bar
    if (path_ok && bars_seen < cfg_m.max_bars && bars_seen < stpl_pkg::COUNT_MAX) begin
      n = bars_seen + 1'b1;
      bars_seen = n;
      if (!long_done) begin
        if (lo_p <= long_stop_lv) begin
          long_done = 1'b1;
          long_bars = n;
        end else if (hi_p >= long_tgt_lv) begin
          long_done = 1'b1;
          long_tgt_hit = 1'b1;
          long_bars = n;
        end
      end
      if (!short_done) begin
        if (hi_p >= short_stop_lv) begin
          short_done = 1'b1;
          short_bars = n;
        end else if (lo_p <= short_tgt_lv) begin
          short_done = 1'b1;
          short_tgt_hit = 1'b1;
          short_bars = n;
        end
      end
    end
    if (!b.last) return;
    v.label = long_tgt_hit ? stpl_pkg::LABEL_LONG
                           : (short_tgt_hit ? stpl_pkg::LABEL_SHORT : stpl_pkg::LABEL_NONE);
    v.long_first = long_tgt_hit;
    v.long_bars = long_bars;
    v.short_first = short_tgt_hit;
    v.short_bars = short_bars;
    verdict_q.push_back(v);
    clear_path();
  endfunction

  // ---------------------------------------------------------------
  // Driver: one beat in flight, random gap after each accepted beat
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      tx_next = in_valid;
      if (in_valid && !in_stall) begin
        track_beat(cur_beat);
        beats_taken++;
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, IDLE_MAX);
        tx_next = 1'b0;
      end
      if (!tx_next) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          action <= cur_beat.action;
          entry_price <= cur_beat.entry;
          bar_high <= cur_beat.high;
          bar_low <= cur_beat.low;
          last_bar <= cur_beat.last;
          tx_next = 1'b1;
        end
      end
      in_valid <= tx_next;
    end
  end

  // ---------------------------------------------------------------
  // Monitor: compare each result, then stall a random while
  // ---------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("label: result with none pending, got %0d", label);
          err_count++;
        end else begin
          want = verdict_q.pop_front();
          check_field("label", want.label, label);
          check_field("long_target_first", want.long_first, long_target_first);
          check_field("long_bar_count", want.long_bars, long_bar_count);
          check_field("short_target_first", want.short_first, short_target_first);
          check_field("short_bar_count", want.short_bars, short_bar_count);
        end
        if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, IDLE_MAX);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= hold_off || (rx_wait > 0);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------
  task automatic apb_cycle(input logic wr, input logic [2:0] idx,
                           input logic [stpl_pkg::DATA_W-1:0] wdata,
                           output logic [stpl_pkg::DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= stpl_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [stpl_pkg::DATA_W-1:0] reg_value(logic [2:0] idx);
    case (idx)
      stpl_pkg::REG_STOP_FRAC:   return stpl_pkg::DATA_W'(cfg_m.stop_fraction);
      stpl_pkg::REG_STOP_MULT:   return stpl_pkg::DATA_W'(cfg_m.stop_multiple);
      stpl_pkg::REG_TARGET_MULT: return stpl_pkg::DATA_W'(cfg_m.target_multiple);
      stpl_pkg::REG_COST_FRAC:   return stpl_pkg::DATA_W'(cfg_m.cost_buffer_fraction);
      stpl_pkg::REG_MAX_BARS:    return stpl_pkg::DATA_W'(cfg_m.max_bars);
      default:                   return '0;
    endcase
  endfunction

  task automatic cfg_readback(input logic [2:0] idx);
    logic [stpl_pkg::DATA_W-1:0] rd;
    apb_cycle(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx)) begin
      $error("prdata reg %0d: expected %0d, got %0d", idx, reg_value(idx), rd);
      err_count++;
    end
  endtask

  task automatic cfg_set(input logic [2:0] idx, input int val);
    logic [stpl_pkg::DATA_W-1:0] rd;
    apb_cycle(1'b1, idx, stpl_pkg::DATA_W'(val), rd);
    case (idx)
      stpl_pkg::REG_STOP_FRAC:   cfg_m.stop_fraction = val[stpl_pkg::FRAC_W-1:0];
      stpl_pkg::REG_STOP_MULT:   cfg_m.stop_multiple = val[stpl_pkg::FRAC_W-1:0];
      stpl_pkg::REG_TARGET_MULT: cfg_m.target_multiple = val[stpl_pkg::FRAC_W-1:0];
      stpl_pkg::REG_COST_FRAC:   cfg_m.cost_buffer_fraction = val[stpl_pkg::FRAC_W-1:0];
      stpl_pkg::REG_MAX_BARS:    cfg_m.max_bars = val[stpl_pkg::MAXB_W-1:0];
      default: ;
    endcase
    cfg_readback(idx);
  endtask

  task automatic cfg_all(input int sf, input int sm, input int tm, input int cb,
                         input int mb);
    cfg_set(stpl_pkg::REG_STOP_FRAC, sf);
    cfg_set(stpl_pkg::REG_STOP_MULT, sm);
    cfg_set(stpl_pkg::REG_TARGET_MULT, tm);
    cfg_set(stpl_pkg::REG_COST_FRAC, cb);
    cfg_set(stpl_pkg::REG_MAX_BARS, mb);
  endtask

  // Wait for every beat taken and every result seen, then let starts finish
  task automatic wait_idle();
    do @(posedge clk); while (beats_taken != beats_queued || verdict_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------
  function automatic void add_beat(logic act, stpl_pkg::price_t entry,
                                   stpl_pkg::price_t hi, stpl_pkg::price_t lo,
                                   logic last);
    beat_t b;
    b.action = act;
    b.entry = entry;
    b.high = hi;
    b.low = lo;
    b.last = last;
    pending_beats.push_back(b);
    beats_queued++;
  endfunction

  // Start beat; bar fields and last flag carry junk, which must be ignored
  function automatic void add_start(stpl_pkg::price_t entry);
    add_beat(ACT_START, entry, stpl_pkg::price_t'($urandom), stpl_pkg::price_t'($urandom),
             logic'($urandom_range(0, 1)));
  endfunction

  function automatic longint rand_below(longint n);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return longint'(r[62:0] % n);
  endfunction

  function automatic stpl_pkg::price_t clip_price(longint v);
    if (v < 0) return '0;
    if (v > PRICE_TOP) return '1;
    return stpl_pkg::price_t'(v);
  endfunction

  function automatic stpl_pkg::price_t pick_entry();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2, 3: return stpl_pkg::price_t'($urandom);
      4, 5, 6: return stpl_pkg::price_t'($urandom_range(1, 100000));
      7:       return stpl_pkg::price_t'($urandom_range(1, 16));
      8:       return stpl_pkg::price_t'($urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF));
      default: return stpl_pkg::price_t'($urandom_range(1000000, 50000000));
    endcase
  endfunction

  // Start plus bars priced around the levels; closed paths end on a last bar
  function automatic void add_path(stpl_pkg::price_t entry, int nbars, logic closed);
    longint e;
    longint one_r;
    longint sd;
    longint td;
    longint span;
    longint mid;
    longint hi;
    longint lo;
    int     i;
    add_start(entry);
    e = entry;
    one_r = (e * cfg_m.stop_fraction) >> 16;
    sd = (one_r * cfg_m.stop_multiple) >> 8;
    td = ((one_r * cfg_m.target_multiple) >> 8) + ((e * cfg_m.cost_buffer_fraction) >> 16);
    span = ((sd > td) ? sd : td) + 2;
    for (i = 0; i < nbars; i++) begin
      mid = e - span - span / 2 + rand_below(3 * span + 1);
      hi = mid + rand_below(span / 2 + 1);
      lo = mid - rand_below(span / 2 + 1);
      // sometimes land exactly on a level
      case ($urandom_range(0, 9))
        0: hi = e + td;
        1: lo = e - sd;
        2: hi = e + sd;
        3: lo = e - td;
        default: ;
      endcase
      add_beat(ACT_BAR, stpl_pkg::price_t'($urandom), clip_price(hi), clip_price(lo),
               closed && (i == nbars - 1));
    end
  endfunction

  function automatic void random_phase(int n);
    int base;
    base = beats_queued;
    while (beats_queued - base < n) begin
      case ($urandom_range(0, 9))
        0: add_beat(ACT_BAR, stpl_pkg::price_t'($urandom), stpl_pkg::price_t'($urandom),
                    stpl_pkg::price_t'($urandom), $urandom_range(0, 3) == 0);
        1: add_start(pick_entry());
        2: add_path(pick_entry(), $urandom_range(1, 8), 1'b0);
        default: add_path(pick_entry(),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
                                                      : $urandom_range(1, 12),
                          1'b1);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------
  initial begin
    stpl_pkg::price_t e_dir;
    int               i;
    int               k;
    cfg_m.stop_fraction = 16'd655;
    cfg_m.stop_multiple = 16'd256;
    cfg_m.target_multiple = 16'd512;
    cfg_m.cost_buffer_fraction = 16'd0;
    cfg_m.max_bars = 12'd20;
    e_dir = 32'd1000000;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values
    for (i = stpl_pkg::REG_STOP_FRAC; i <= stpl_pkg::REG_MAX_BARS; i++) cfg_readback(3'(i));

    // directed, reset config: levels for 1e6 are 990006/1019988 and 1009994/980012
    add_beat(ACT_BAR, '0, '1, '0, 1'b1);              // last bar with no path
    add_start('0);                                    // zero entry
    add_beat(ACT_BAR, '0, '1, '0, 1'b1);
    add_start(e_dir);                                 // long target exactly, short stop
    add_beat(ACT_BAR, '0, 32'd1019988, e_dir, 1'b1);
    add_start(e_dir);                                 // short target exactly, long stop
    add_beat(ACT_BAR, '0, e_dir, 32'd980012, 1'b1);
    add_start(e_dir);                                 // both stop and target on one bar
    add_beat(ACT_BAR, '0, '1, '0, 1'b1);
    add_start(e_dir);                                 // nothing resolves
    add_beat(ACT_BAR, '0, e_dir, e_dir, 1'b0);
    add_beat(ACT_BAR, '0, e_dir, e_dir, 1'b1);
    add_start('1);                                    // top entry, upper levels above the top price
    add_beat(ACT_BAR, '1, '1, '1, 1'b0);
    add_beat(ACT_BAR, '1, '0, '0, 1'b1);
    add_beat(ACT_START, '0, '1, '1, 1'b1);            // start with last set, no result
    add_start(e_dir);
    add_beat(ACT_BAR, '0, 32'd1019987, 32'd990007, 1'b1);
    add_beat(ACT_BAR, '0, '0, '1, 1'b1);              // bar after the path ended
    wait_idle();

    random_phase(250);
    wait_idle();

    // all fields at their top
    cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
    random_phase(150);
    wait_idle();

    // zero stop fraction: no path ever valid
    cfg_all(0, $urandom_range(0, 1024), $urandom_range(0, 2048), $urandom_range(0, 3000),
            4095);
    random_phase(80);
    wait_idle();

    // zero distances: all levels equal the entry
    cfg_all($urandom_range(1, 8000), 0, 0, 0, 20);
    random_phase(80);
    wait_idle();

    // random settings, first one with a zero bar window
    for (k = 0; k < 4; k++) begin
      cfg_all($urandom_range(1, 8000), $urandom_range(0, 1024), $urandom_range(0, 2048),
              $urandom_range(0, 3000), (k == 0) ? 0 : $urandom_range(1, 40));
      random_phase(200);
      wait_idle();
    end

    // back-pressure: short paths while the output is held off
    cfg_all(655, 256, 512, 100, 3);
    pressure_go = 1'b1;
    for (k = 0; k < 60; k++) add_path(pick_entry(), $urandom_range(1, 2), 1'b1);
    wait_idle();

    if (err_count == 0) begin
      $display("** stop_target_path_labeler: PASSED **");
    end else begin
      $display("** stop_target_path_labeler: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("** stop_target_path_labeler: FAILED **");
    $finish;
  end

endmodule
